/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PCC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define PCC_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and constants of the PCM companding codec.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam logic LAW_ALAW  = 1'b0;
    localparam logic LAW_MULAW = 1'b1;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic [7:0]  ALAW_XOR_MASK = 8'h55;
    localparam logic [16:0] MU_OFFSET     = 17'd132;
    localparam logic [14:0] SEG_BASE      = 15'h0084;
    localparam logic [14:0] MAG_MAX       = 15'h7FFF;

    typedef struct packed {
        logic        req_type;
        logic [15:0] pcm_sample;
        logic [7:0]  law_code;
        logic        last_sample;
    } item_t;

    typedef struct packed {
        logic [7:0]  code_out;
        logic [15:0] pcm_out;
        logic        last_out;
    } result_t;

    // Segment number: 1 to 7 for the highest set bit among bits 8..14, 0 if none is set.
    function automatic logic [2:0] seg_of(input logic [14:0] mag);
        logic [2:0] seg;
        seg = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (mag[i + 7]) begin
                seg = 3'(i);
            end
        end
        return seg;
    endfunction

endpackage

/* rtl/pcc_core.sv */
// ----------------------------------------------------------------------------
// pcc_core
// Single-pass A-law / mu-law encode and decode of one sample.
// ----------------------------------------------------------------------------
module pcc_core (
    input  pcc_pkg::item_t   item,
    input  logic             law_sel,
    output pcc_pkg::result_t res
);

    // A-law encode
    logic        ae_sign;
    logic [14:0] ae_mag;
    logic [2:0]  ae_exp;
    logic [3:0]  ae_shamt;
    logic [14:0] ae_shifted;
    logic [7:0]  ae_code;

    // mu-law encode
    logic        ue_sign;
    logic [15:0] ue_abs;
    logic [16:0] ue_sum;
    logic [14:0] ue_mag;
    logic [2:0]  ue_exp;
    logic [3:0]  ue_shamt;
    logic [14:0] ue_shifted;
    logic [7:0]  ue_code;

    // A-law decode
    logic [7:0]  ad_t;
    logic [14:0] ad_mag;
    logic [15:0] ad_pcm;

    // mu-law decode
    logic [7:0]  ud_t;
    logic [14:0] ud_mag;
    logic [15:0] ud_pcm;

    always_comb begin
        // one's complement of negative samples
        ae_sign    = item.pcm_sample[15];
        ae_mag     = ae_sign ? ~item.pcm_sample[14:0] : item.pcm_sample[14:0];
        ae_exp     = pcc_pkg::seg_of(ae_mag);
        ae_shamt   = (ae_exp == 3'd0) ? 4'd4 : ({1'b0, ae_exp} + 4'd3);
        ae_shifted = ae_mag >> ae_shamt;
        ae_code    = pcc_pkg::ALAW_XOR_MASK ^ {ae_sign, ae_exp, ae_shifted[3:0]};

        // two's complement magnitude, bias, saturate
        ue_sign    = item.pcm_sample[15];
        ue_abs     = ue_sign ? (~item.pcm_sample + 16'd1) : item.pcm_sample;
        ue_sum     = {1'b0, ue_abs} + pcc_pkg::MU_OFFSET;
        ue_mag     = (ue_sum > {2'b00, pcc_pkg::MAG_MAX}) ? pcc_pkg::MAG_MAX : ue_sum[14:0];
        ue_exp     = pcc_pkg::seg_of(ue_mag);
        ue_shamt   = {1'b0, ue_exp} + 4'd3;
        ue_shifted = ue_mag >> ue_shamt;
        ue_code    = ~{ue_sign, ue_exp, ue_shifted[3:0]};

        ad_t = item.law_code ^ pcc_pkg::ALAW_XOR_MASK;
        if (ad_t[6:4] != 3'd0) begin
            ad_mag = ({8'd0, ad_t[3:0], 3'd0} | pcc_pkg::SEG_BASE) << ad_t[6:4];
        end else begin
            ad_mag = {7'd0, ad_t[3:0], 4'h8};
        end
        ad_pcm = ad_t[7] ? (16'd0 - {1'b0, ad_mag}) : {1'b0, ad_mag};

        ud_t   = ~item.law_code;
        ud_mag = ((pcc_pkg::SEG_BASE << ud_t[6:4])
                 | ({11'd0, ud_t[3:0]} << ({1'b0, ud_t[6:4]} + 4'd3)))
                 - pcc_pkg::MU_OFFSET[14:0];
        ud_pcm = ud_t[7] ? (16'd0 - {1'b0, ud_mag}) : {1'b0, ud_mag};

        res.code_out = 8'd0;
        res.pcm_out  = 16'd0;
        res.last_out = item.last_sample;
        case (item.req_type)
            pcc_pkg::REQ_ENCODE: begin
                res.code_out = (law_sel == pcc_pkg::LAW_MULAW) ? ue_code : ae_code;
            end
            pcc_pkg::REQ_DECODE: begin
                res.pcm_out = (law_sel == pcc_pkg::LAW_MULAW) ? ud_pcm : ad_pcm;
            end
            default: begin
                res.code_out = 8'd0;
            end
        endcase
    end

endmodule

/* rtl/pcm_companding_codec.sv */
// ----------------------------------------------------------------------------
// pcm_companding_codec
// Stream A-law / mu-law companding codec, one sample per beat.
// ----------------------------------------------------------------------------
// Each input beat is a request: tuser low encodes the signed 16-bit sample in
// s_tdata[15:0] into one code byte, tuser high decodes the code byte in
// s_tdata[23:16] into a signed 16-bit sample. The result beat carries the code
// byte in m_tdata[7:0] (zero when decoding) and the sample in m_tdata[23:8]
// (zero when encoding); tlast is passed straight through. The law is chosen
// by the one-bit register written on the cfg channel (0 A-law, 1 mu-law, reset
// A-law); write it only while no beat is in flight. The block takes one beat
// every cycle while the result side keeps up: one input register, the
// encode/decode logic, one result register. A beat is captured in the input
// register, and its result is loaded into the result register and offered
// on m_tvalid once that register is empty or its beat leaves. A result held
// back by m_tready stays in the result register; the input register still
// takes one more beat, after which s_tready follows m_tready until the
// result leaves. At most two beats are held inside.
// ----------------------------------------------------------------------------
module pcm_companding_codec (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // law_select

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [15:0] pcm_sample, [23:16] law_code
    input  logic        s_tuser,       // req_type
    input  logic        s_tlast,       // last_sample

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] code_out, [23:8] pcm_out
    output logic        m_tlast        // last_out
);

    logic             law_sel_reg;
    logic             law_sel_next;

    pcc_pkg::item_t   in_item_reg;
    pcc_pkg::item_t   in_item_next;
    logic             in_valid_reg;
    logic             in_valid_next;

    pcc_pkg::result_t out_res_reg;
    pcc_pkg::result_t out_res_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    pcc_pkg::result_t core_res;
    logic             out_ready;
    logic             in_take;
    logic             out_take;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    // Result stage frees up when empty or when its beat leaves this cycle.
    assign out_ready = !out_valid_reg || m_tready;
    assign out_take  = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;

    pcc_core u_core (
        .item    (in_item_reg),
        .law_sel (law_sel_reg),
        .res     (core_res)
    );

    always_comb begin
        law_sel_next = law_sel_reg;
        if (cfg_valid && cfg_ready) begin
            law_sel_next = cfg_data;
        end

        // Input register: capture a new beat, otherwise hold or drain.
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_item_next.req_type    = s_tuser;
            in_item_next.pcm_sample  = s_tdata[15:0];
            in_item_next.law_code    = s_tdata[23:16];
            in_item_next.last_sample = s_tlast;
            in_valid_next            = 1'b1;
        end else if (out_take) begin
            in_valid_next = 1'b0;
        end

        // Result register: load from the core, hold while stalled, empty once its beat leaves.
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (out_take) begin
            out_res_next   = core_res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            law_sel_reg   <= pcc_pkg::LAW_ALAW;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            law_sel_reg   <= law_sel_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.pcm_out, out_res_reg.code_out};
    assign m_tlast  = out_res_reg.last_out;

endmodule

/* rtl/pcc_checker.sv */
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the PCM companding codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result beat.
    `PCC_ASSERT_RST(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed or dropped")

    // Never emit a result in the cycle after reset.
    `PCC_ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid straight after reset")

    // An empty result stage leaves room for a new input beat.
    `PCC_ASSERT_RST(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled while result stage is empty")

    // Only one of code byte and sample may be non-zero.
    `PCC_ASSERT_RST(a_one_field, aclk, aresetn, m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[23:8] == 16'd0), "both code byte and sample non-zero")

endmodule

bind pcm_companding_codec pcc_checker u_pcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the A-law / mu-law companding codec.
// ----------------------------------------------------------------------------
// A short table of directed samples is walked first: zero, the full-scale
// and most negative samples, minus one, segment and saturation edges, and
// the code bytes that decode to the extremes and to zero, under both laws.
// Several hundred random samples follow, with the law switched between
// phases. Every accepted beat is predicted by a local model of the codec
// or by its table row, and compared field by field with the result beats,
// in order. Both sides idle at random, and once the result side holds off
// for a long stretch so that the pipeline fills and stalls the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam int          STUCK_LIMIT   = 2000;  // cycles with no beat anywhere
    localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int          PIPE_SETTLE   = 4;     // covers the two pipeline registers
    localparam int          RAND_PHASES   = 6;
    localparam int          PHASE_ITEMS   = 64;
    localparam logic [7:0]  ALAW_TOGGLE   = 8'h55;
    localparam logic [16:0] MU_BIAS       = 17'd132;
    localparam logic [16:0] MU_CLIP       = 17'h07FFF;

    // One companded result as it appears on the master side.
    typedef struct packed {
        logic [7:0]  code_byte;
        logic [15:0] pcm_word;
        logic        last_flag;
    } sample_result_t;

    // One row of directed stimulus; typed rows carry their own answer.
    typedef struct packed {
        logic        law;
        logic        req;
        logic [15:0] pcm;
        logic [7:0]  code;
        logic        last;
        bit          typed;
        logic [7:0]  want_code;
        logic [15:0] want_pcm;
    } stim_row_t;

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // A-law encode: zero, full scale, most negative, minus one
        '{LAW_ALAW,  REQ_ENCODE, 16'h0000, 8'hA5, 1'b0, 1'b1, 8'h55, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'h7FFF, 8'h00, 1'b0, 1'b1, 8'h2A, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'h8000, 8'hFF, 1'b1, 1'b1, 8'hAA, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'hFFFF, 8'h5A, 1'b0, 1'b1, 8'hD5, 16'h0000},
        // A-law encode: segment edges, left to the predictor
        '{LAW_ALAW,  REQ_ENCODE, 16'h0001, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'h00FF, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'h0100, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{LAW_ALAW,  REQ_ENCODE, 16'hFF00, 8'h00, 1'b1, 1'b0, 8'h00, 16'h0000},
        // A-law decode: smallest and largest magnitudes of either sign, two more left to the predictor
        '{LAW_ALAW,  REQ_DECODE, 16'h5A5A, 8'h55, 1'b0, 1'b1, 8'h00, 16'h0008},
        '{LAW_ALAW,  REQ_DECODE, 16'hA5A5, 8'hD5, 1'b0, 1'b1, 8'h00, 16'hFFF8},
        '{LAW_ALAW,  REQ_DECODE, 16'h0000, 8'h2A, 1'b0, 1'b1, 8'h00, 16'h7E00},
        '{LAW_ALAW,  REQ_DECODE, 16'hFFFF, 8'hAA, 1'b1, 1'b1, 8'h00, 16'h8200},
        '{LAW_ALAW,  REQ_DECODE, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{LAW_ALAW,  REQ_DECODE, 16'h0000, 8'hFF, 1'b1, 1'b0, 8'h00, 16'h0000},
        // mu-law encode: zero, full scale, most negative (saturates), minus one
        '{LAW_MULAW, REQ_ENCODE, 16'h0000, 8'h3C, 1'b0, 1'b1, 8'hFF, 16'h0000},
        '{LAW_MULAW, REQ_ENCODE, 16'h7FFF, 8'h00, 1'b0, 1'b1, 8'h80, 16'h0000},
        '{LAW_MULAW, REQ_ENCODE, 16'h8000, 8'hFF, 1'b1, 1'b1, 8'h00, 16'h0000},
        '{LAW_MULAW, REQ_ENCODE, 16'hFFFF, 8'h00, 1'b0, 1'b1, 8'h7F, 16'h0000},
        // mu-law encode: either side of the bias saturation point
        '{LAW_MULAW, REQ_ENCODE, 16'd32635, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{LAW_MULAW, REQ_ENCODE, 16'h8084, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
        // mu-law decode: negative zero, positive zero, largest magnitudes
        '{LAW_MULAW, REQ_DECODE, 16'hFFFF, 8'h7F, 1'b0, 1'b1, 8'h00, 16'h0000},
        '{LAW_MULAW, REQ_DECODE, 16'h0000, 8'hFF, 1'b0, 1'b1, 8'h00, 16'h0000},
        '{LAW_MULAW, REQ_DECODE, 16'h1234, 8'h00, 1'b1, 1'b1, 8'h00, 16'h8284},
        '{LAW_MULAW, REQ_DECODE, 16'h0000, 8'h80, 1'b1, 1'b0, 8'h00, 16'h0000}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] pcm_sample, [23:16] law_code
    logic        s_tuser;   // req_type
    logic        s_tlast;   // last_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] code_out, [23:8] pcm_out
    logic        m_tlast;   // last_out

    // Law the predictor assumes; follows each accepted cfg beat.
    logic           law_setting;
    // Answer for the beat currently offered, queued when the beat is taken.
    sample_result_t offered_answer;
    sample_result_t awaited_results[$];
    sample_result_t oldest_result;
    int             mismatches;
    int             samples_sent;
    int             cycle_no;
    int             stuck_cycles;
    bit             hold_request;

    pcm_companding_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Companding model
    // ------------------------------------------------------------------------

    // A-law works on the one's complement of negative samples; segment 0
    // shares the step size of segment 1.
    function automatic logic [7:0] alaw_compress(input logic [15:0] s);
        logic [14:0] mag;
        logic [2:0]  seg;
        logic [3:0]  mant;
        mag = s[15] ? ~s[14:0] : s[14:0];
        seg = 3'd7;
        while (seg != 3'd0 && !mag[seg + 7]) begin
            seg = seg - 3'd1;
        end
        mant = (seg == 3'd0) ? mag[7:4] : 4'(mag >> (seg + 3));
        return ALAW_TOGGLE ^ {s[15], seg, mant};
    endfunction

    // mu-law biases the true magnitude and clips it at the top of the scale.
    function automatic logic [7:0] ulaw_compress(input logic [15:0] s);
        logic [16:0] mag;
        logic [2:0]  seg;
        logic [3:0]  mant;
        mag = s[15] ? 17'h10000 - {1'b0, s} : {1'b0, s};
        mag = mag + MU_BIAS;
        if (mag > MU_CLIP) begin
            mag = MU_CLIP;
        end
        seg = 3'd7;
        while (seg != 3'd0 && !mag[seg + 7]) begin
            seg = seg - 3'd1;
        end
        mant = 4'(mag >> (seg + 3));
        return ~{s[15], seg, mant};
    endfunction

    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  t;
        logic [15:0] mag;
        t = code ^ ALAW_TOGGLE;
        if (t[6:4] != 3'd0) begin
            mag = {8'h00, 1'b1, t[3:0], 3'b100} << t[6:4];
        end else begin
            mag = {8'h00, t[3:0], 4'b1000};
        end
        return t[7] ? -mag : mag;
    endfunction

    function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
        logic [7:0]  t;
        logic [15:0] mag;
        t = ~code;
        mag = ({8'h00, 1'b1, t[3:0], 3'b100} << t[6:4]) - 16'(MU_BIAS);
        return t[7] ? -mag : mag;
    endfunction

    function automatic sample_result_t companded_result(input logic law, input logic req,
                                                        input logic [15:0] pcm,
                                                        input logic [7:0] code,
                                                        input logic last);
        sample_result_t r;
        r = '0;
        r.last_flag = last;
        if (req == REQ_ENCODE) begin
            r.code_byte = (law == LAW_MULAW) ? ulaw_compress(pcm) : alaw_compress(pcm);
        end else begin
            r.pcm_word = (law == LAW_MULAW) ? ulaw_expand(code) : alaw_expand(code);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor and scoreboard
    // ------------------------------------------------------------------------

    // Queue the answer first, then retire a result: both sampled at the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(offered_answer);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing awaited: code %h pcm %h last %b",
                             $time, m_tdata[7:0], m_tdata[23:8], m_tlast);
                    mismatches++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (m_tdata[7:0] !== oldest_result.code_byte) begin
                        $display("%0t: code_out expected %h actual %h",
                                 $time, oldest_result.code_byte, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[23:8] !== oldest_result.pcm_word) begin
                        $display("%0t: pcm_out expected %h actual %h",
                                 $time, oldest_result.pcm_word, m_tdata[23:8]);
                        mismatches++;
                    end
                    if (m_tlast !== oldest_result.last_flag) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, oldest_result.last_flag, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results awaited",
                     $time, STUCK_LIMIT, awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, quiet stretches and one long hold
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // Hold off long enough for the input side to back up.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else if ((cycle_no % 160) < 40) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    task automatic wait_until_drained();
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Stop offering, let the pipeline empty, then write the law register.
    task automatic write_law(input logic law);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_until_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= law;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        law_setting = law;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample after a random gap and return once it is taken.
    task automatic send_sample(input logic req, input logic [15:0] pcm,
                               input logic [7:0] code, input logic last,
                               input bit typed, input logic [7:0] want_code,
                               input logic [15:0] want_pcm);
        int gap;
        if (hold_request || (samples_sent % 64) < 12) begin
            gap = 0;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(6, 30);
            endcase
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {code, pcm};
        s_tuser  <= req;
        s_tlast  <= last;
        if (typed) begin
            offered_answer = '{code_byte: want_code, pcm_word: want_pcm, last_flag: last};
        end else begin
            offered_answer = companded_result(law_setting, req, pcm, code, last);
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    // Random sample, weighted toward small magnitudes, segment edges,
    // the full-scale ends and the mu-law clipping point.
    function automatic logic [15:0] random_sample();
        logic [15:0] v;
        int          k;
        k = $urandom_range(0, 14);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom);
            4, 5:       v = 16'($urandom_range(0, (1 << k) - 1));
            6, 7:       v = 16'((1 << k) + $urandom_range(0, 4)) - 16'd2;
            8: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default:    v = 16'd32635 + 16'($urandom_range(0, 6)) - 16'd3;
        endcase
        // Flip to the negative side half the time, both by negation and by
        // one's complement, so either convention's edge is hit.
        if ($urandom_range(0, 1)) begin
            v = $urandom_range(0, 1) ? -v : ~v;
        end
        return v;
    endfunction

    initial begin
        logic      current_law;
        bit        law_known;
        stim_row_t row;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        law_setting  = LAW_ALAW;
        offered_answer = '0;
        mismatches   = 0;
        samples_sent = 0;
        cycle_no     = 0;
        stuck_cycles = 0;
        hold_request = 1'b0;
        law_known    = 1'b0;
        current_law  = LAW_ALAW;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table; rewrite the law whenever a row asks for another one.
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (!law_known || row.law != current_law) begin
                write_law(row.law);
                current_law = row.law;
                law_known   = 1'b1;
            end
            send_sample(row.req, row.pcm, row.code, row.last,
                        row.typed, row.want_code, row.want_pcm);
        end

        // Random phases, alternating the law; the second one carries the
        // long hold-off on the result side.
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_law((p % 2 == 0) ? LAW_ALAW : LAW_MULAW);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20) begin
                    hold_request = 1'b1;
                end
                send_sample($urandom_range(0, 1) ? REQ_DECODE : REQ_ENCODE,
                            random_sample(), 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 7) == 0), 1'b0, 8'h00, 16'h0000);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_until_drained();
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
